// ===== rtl/fatdf_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the float audio to device format unit
package fatdf_pkg;

   localparam int DefaultMaxChannels = 8;
   localparam int ChannelCountWidth  = 4;

   localparam logic [1:0] CSR_DEST_CHANNELS = 2'd0;
   localparam logic [1:0] CSR_SAMPLE_FORMAT = 2'd1;
   localparam logic [1:0] CSR_SOURCE_STEREO = 2'd2;

   typedef enum logic [1:0] {
      FMT_FLOAT32 = 2'd0,
      FMT_PCM16   = 2'd1,
      FMT_PCM32   = 2'd2,
      FMT_NONE    = 2'd3
   } format_type;

   localparam logic [31:0] FloatOne     = 32'h3F80_0000;
   localparam logic [31:0] DefaultNan   = 32'hFFC0_0000;
   localparam logic [31:0] QuietBit     = 32'h0040_0000;
   localparam logic [14:0] Pcm16Scale   = 15'h7FFF;
   localparam logic [31:0] Pcm32Max     = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [2:0] channel;
      logic       frame_done;
      logic       buffer_done;
   } tag_type;

endpackage

// ===== rtl/fatdf_expander.sv =====
`timescale 1ns / 1ps
// frame register and channel sequencer, one channel operation per cycle while op_ready is high
module fatdf_expander #(
   parameter int MAX_CHANNELS = fatdf_pkg::DefaultMaxChannels
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [31:0]         req_left_sample,
   input  logic [31:0]         req_right_sample,
   input  logic                req_final_frame,
   input  logic [3:0]          dest_channels,
   input  logic                source_stereo,
   output logic                op_valid,
   input  logic                op_ready,
   output logic [31:0]         op_a,
   output logic [31:0]         op_b,
   output logic                op_add,
   output fatdf_pkg::tag_type  op_tag
);
   import fatdf_pkg::*;

   localparam int Limit = (MAX_CHANNELS > 15) ? 15 : MAX_CHANNELS;
   localparam logic [ChannelCountWidth-1:0] LimitCount = ChannelCountWidth'(Limit);

   logic                         busy_ff, busy_in;
   logic [31:0]                  left_ff, left_in, right_ff, right_in;
   logic                         final_ff, final_in;
   logic [ChannelCountWidth-1:0] count_ff, count_in, ch_ff, ch_in;
   logic [ChannelCountWidth-1:0] count_raw, count_req;
   logic                         last, issue, take;

   always_comb begin
      count_raw = (dest_channels == '0) ? ChannelCountWidth'(2) : dest_channels;
      count_req = (count_raw > LimitCount) ? LimitCount : count_raw;
   end

   assign last      = (ch_ff + ChannelCountWidth'(1)) == count_ff;
   assign issue     = busy_ff && op_ready;
   assign req_stall = busy_ff && !(op_ready && last);
   assign take      = req_valid && !req_stall;

   always_comb begin
      busy_in  = busy_ff;
      ch_in    = ch_ff;
      left_in  = left_ff;
      right_in = right_ff;
      final_in = final_ff;
      count_in = count_ff;
      if (take) begin
         busy_in  = 1'b1;
         ch_in    = '0;
         left_in  = req_left_sample;
         right_in = source_stereo ? req_right_sample : req_left_sample;
         final_in = req_final_frame;
         count_in = count_req;
      end else if (issue) begin
         busy_in = !last;
         ch_in   = ch_ff + ChannelCountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         ch_ff    <= '0;
         count_ff <= ChannelCountWidth'(2);
      end else begin
         busy_ff  <= busy_in;
         ch_ff    <= ch_in;
         count_ff <= count_in;
      end
      left_ff  <= left_in;
      right_ff <= right_in;
      final_ff <= final_in;
   end

   // downmix on a single channel, else left, right, then silence
   always_comb begin
      op_add = (count_ff == ChannelCountWidth'(1));
      op_b   = right_ff;
      if (op_add || ch_ff == '0) begin
         op_a = left_ff;
      end else if (ch_ff == ChannelCountWidth'(1)) begin
         op_a = right_ff;
      end else begin
         op_a = '0;
      end
      op_tag.channel     = ch_ff[2:0];
      op_tag.frame_done  = last;
      op_tag.buffer_done = last && final_ff;
   end

   assign op_valid = busy_ff;

   a_ch_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (ch_ff < count_ff))
      else $error("channel counter past frame width");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (count_ff != '0))
      else $error("frame with no channels");

   a_frame_ends: assert property (@(posedge clock) disable iff (reset)
      (issue && last && !take) |=> !busy_ff)
      else $error("sequencer kept running after last channel");

endmodule

// ===== rtl/fatdf_adder.sv =====
`timescale 1ns / 1ps
// three stage single precision add and halve, with pass-through for plain channels
module fatdf_adder (
   input  logic                clock,
   input  logic                reset,
   input  logic                op_valid,
   output logic                op_ready,
   input  logic [31:0]         op_a,
   input  logic [31:0]         op_b,
   input  logic                op_add,
   input  fatdf_pkg::tag_type  op_tag,
   output logic                val_valid,
   input  logic                val_ready,
   output logic [31:0]         val_word,
   output fatdf_pkg::tag_type  val_tag
);
   import fatdf_pkg::*;

   function automatic logic [4:0] lead_zeros(input logic [26:0] v);
      logic [4:0] n;
      logic       found;
      n     = 5'd27;
      found = 1'b0;
      for (int i = 26; i >= 0; i--) begin
         if (!found && v[i]) begin
            n     = 5'(26 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   logic r1, r2, r3;

   // stage 1: specials, order by magnitude, align
   logic        s1_valid_ff;
   logic        s1_special_ff, s1_special_in;
   logic [31:0] s1_word_ff, s1_word_in;
   logic        s1_sign_ff, s1_sign_in, s1_sub_ff, s1_sub_in;
   logic [7:0]  s1_exp_ff, s1_exp_in;
   logic [26:0] s1_big_ff, s1_big_in, s1_small_ff, s1_small_in;
   tag_type     s1_tag_ff;

   logic        a_nan, b_nan, a_inf, b_inf;
   logic [31:0] x, y;
   logic [7:0]  ex, ey, d;
   logic [23:0] mx, my;
   logic [26:0] y_ext, y_shift;
   logic        y_lost;

   always_comb begin
      a_nan = (&op_a[30:23]) && (|op_a[22:0]);
      b_nan = (&op_b[30:23]) && (|op_b[22:0]);
      a_inf = (&op_a[30:23]) && !(|op_a[22:0]);
      b_inf = (&op_b[30:23]) && !(|op_b[22:0]);
      s1_special_in = 1'b1;
      s1_word_in    = op_a;
      if (!op_add) begin
         s1_word_in = op_a;
      end else if (a_nan) begin
         s1_word_in = op_a | QuietBit;
      end else if (b_nan) begin
         s1_word_in = op_b | QuietBit;
      end else if (a_inf && b_inf && (op_a[31] != op_b[31])) begin
         s1_word_in = DefaultNan;
      end else if (a_inf) begin
         s1_word_in = op_a;
      end else if (b_inf) begin
         s1_word_in = op_b;
      end else begin
         s1_special_in = 1'b0;
      end

      if (op_b[30:0] > op_a[30:0]) begin
         x = op_b;
         y = op_a;
      end else begin
         x = op_a;
         y = op_b;
      end
      ex = (x[30:23] == '0) ? 8'd1 : x[30:23];
      ey = (y[30:23] == '0) ? 8'd1 : y[30:23];
      mx = {x[30:23] != '0, x[22:0]};
      my = {y[30:23] != '0, y[22:0]};
      d  = ex - ey;
      y_ext = {my, 3'b000};
      if (d >= 8'd27) begin
         y_shift = '0;
         y_lost  = |my;
      end else begin
         y_shift = y_ext >> d[4:0];
         y_lost  = |(y_ext & ~({27{1'b1}} << d[4:0]));
      end
      s1_big_in   = {mx, 3'b000};
      s1_small_in = {y_shift[26:1], y_shift[0] | y_lost};
      s1_exp_in   = ex;
      s1_sign_in  = x[31];
      s1_sub_in   = x[31] ^ y[31];
   end

   // stage 2: add or subtract, count leading zeros
   logic        s2_valid_ff;
   logic        s2_special_ff;
   logic [31:0] s2_word_ff;
   logic        s2_sign_ff, s2_sub_ff;
   logic [7:0]  s2_exp_ff;
   logic [27:0] s2_sum_ff, s2_sum_in;
   logic [4:0]  s2_lz_ff, s2_lz_in;
   tag_type     s2_tag_ff;

   always_comb begin
      s2_sum_in = s1_sub_ff ? ({1'b0, s1_big_ff} - {1'b0, s1_small_ff})
                            : ({1'b0, s1_big_ff} + {1'b0, s1_small_ff});
      s2_lz_in  = lead_zeros(s2_sum_in[26:0]);
   end

   // stage 3: normalize, round to nearest even, then halve
   logic        s3_valid_ff;
   logic [31:0] s3_word_ff, s3_word_in;
   tag_type     s3_tag_ff;

   logic [8:0]  e9, lim, sh;
   logic [26:0] mant;
   logic        inc;
   logic [31:0] pk, sum_word;
   logic [7:0]  se;
   logic [23:0] mag24, h24;

   always_comb begin
      lim = {1'b0, s2_exp_ff} - 9'd1;
      sh  = ({4'b0, s2_lz_ff} < lim) ? {4'b0, s2_lz_ff} : lim;
      if (s2_sum_ff[27]) begin
         mant = {s2_sum_ff[27:2], s2_sum_ff[1] | s2_sum_ff[0]};
         e9   = {1'b0, s2_exp_ff} + 9'd1;
      end else begin
         mant = s2_sum_ff[26:0] << sh;
         e9   = {1'b0, s2_exp_ff} - sh;
      end
      inc = mant[2] && ((|mant[1:0]) || mant[3]);
      pk  = {e9 - 9'd1, 23'b0} + {8'b0, mant[26:3]} + {31'b0, inc};
      if (s2_sum_ff == '0) begin
         sum_word = {s2_sign_ff && !s2_sub_ff, 31'b0};
      end else if (pk[31:23] >= 9'd255) begin
         sum_word = {s2_sign_ff, 8'hFF, 23'b0};
      end else begin
         sum_word = {s2_sign_ff, pk[30:0]};
      end

      se    = sum_word[30:23];
      mag24 = {se[0], sum_word[22:0]};
      h24   = {1'b0, mag24[23:1]} + {23'b0, mag24[0] && mag24[1]};
      if (s2_special_ff) begin
         s3_word_in = s2_word_ff;
      end else if (se == 8'hFF) begin
         s3_word_in = sum_word;
      end else if (se >= 8'd2) begin
         s3_word_in = {sum_word[31], se - 8'd1, sum_word[22:0]};
      end else begin
         s3_word_in = {sum_word[31], 7'b0, h24};
      end
   end

   assign r3       = !s3_valid_ff || val_ready;
   assign r2       = !s2_valid_ff || r3;
   assign r1       = !s1_valid_ff || r2;
   assign op_ready = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (r1) s1_valid_ff <= op_valid;
         if (r2) s2_valid_ff <= s1_valid_ff;
         if (r3) s3_valid_ff <= s2_valid_ff;
      end
      if (r1) begin
         s1_special_ff <= s1_special_in;
         s1_word_ff    <= s1_word_in;
         s1_sign_ff    <= s1_sign_in;
         s1_sub_ff     <= s1_sub_in;
         s1_exp_ff     <= s1_exp_in;
         s1_big_ff     <= s1_big_in;
         s1_small_ff   <= s1_small_in;
         s1_tag_ff     <= op_tag;
      end
      if (r2) begin
         s2_special_ff <= s1_special_ff;
         s2_word_ff    <= s1_word_ff;
         s2_sign_ff    <= s1_sign_ff;
         s2_sub_ff     <= s1_sub_ff;
         s2_exp_ff     <= s1_exp_ff;
         s2_sum_ff     <= s2_sum_in;
         s2_lz_ff      <= s2_lz_in;
         s2_tag_ff     <= s1_tag_ff;
      end
      if (r3) begin
         s3_word_ff <= s3_word_in;
         s3_tag_ff  <= s2_tag_ff;
      end
   end

   assign val_valid = s3_valid_ff;
   assign val_word  = s3_word_ff;
   assign val_tag   = s3_tag_ff;

endmodule

// ===== rtl/fatdf_encoder.sv =====
`timescale 1ns / 1ps
// clamp, scale and pack into the device sample format, two stages
module fatdf_encoder (
   input  logic                clock,
   input  logic                reset,
   input  logic                val_valid,
   output logic                val_ready,
   input  logic [31:0]         val_word,
   input  fatdf_pkg::tag_type  val_tag,
   input  logic [1:0]          sample_format,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [31:0]         rsp_sample_word,
   output logic [2:0]          rsp_channel_index,
   output logic                rsp_frame_done,
   output logic                rsp_buffer_done
);
   import fatdf_pkg::*;

   logic r4, r5;

   // stage 4: clamp to [-1,1], pcm16 product
   logic        s4_valid_ff;
   logic [31:0] s4_c_ff, s4_c_in;
   logic        s4_nan_ff, s4_nan_in;
   logic [38:0] s4_prod_ff, s4_prod_in;
   tag_type     s4_tag_ff;

   always_comb begin
      s4_nan_in  = (&val_word[30:23]) && (|val_word[22:0]);
      s4_c_in    = (!s4_nan_in && val_word[30:0] > FloatOne[30:0])
                   ? {val_word[31], FloatOne[30:0]} : val_word;
      s4_prod_in = 39'({1'b1, s4_c_in[22:0]}) * 39'(Pcm16Scale);
   end

   // stage 5: round, truncate, select format
   logic        out_valid_ff;
   logic [31:0] out_word_ff, out_word_in;
   tag_type     out_tag_ff;

   logic [7:0]  ce;
   logic        hi, g, st;
   logic [23:0] m16;
   logic [24:0] mr16, int16;
   logic [7:0]  sh16;
   logic [15:0] pcm16;
   logic [31:0] m32, mag32, pcm32;

   always_comb begin
      ce   = s4_c_ff[30:23];
      hi   = s4_prod_ff[38];
      m16  = hi ? s4_prod_ff[38:15] : s4_prod_ff[37:14];
      g    = hi ? s4_prod_ff[14] : s4_prod_ff[13];
      st   = hi ? (|s4_prod_ff[13:0]) : (|s4_prod_ff[12:0]);
      mr16 = {1'b0, m16} + {24'b0, g && (st || m16[0])};
      sh16 = hi ? (8'd135 - ce) : (8'd136 - ce);
      int16 = mr16 >> sh16[4:0];
      if (ce < 8'd112) begin
         pcm16 = '0;
      end else begin
         pcm16 = s4_c_ff[31] ? (16'd0 - int16[15:0]) : int16[15:0];
      end

      m32 = {8'b0, 1'b1, s4_c_ff[22:0]};
      if (ce >= 8'd119) begin
         mag32 = m32 << (ce - 8'd119);
      end else begin
         mag32 = m32 >> (8'd119 - ce);
      end
      if (ce < 8'd96) begin
         pcm32 = '0;
      end else if (s4_c_ff[31]) begin
         pcm32 = 32'd0 - mag32;
      end else begin
         pcm32 = mag32[31] ? Pcm32Max : mag32;
      end

      unique case (format_type'(sample_format))
         FMT_FLOAT32: out_word_in = s4_c_ff;
         FMT_PCM16:   out_word_in = s4_nan_ff ? 32'd0 : {16'b0, pcm16};
         FMT_PCM32:   out_word_in = s4_nan_ff ? 32'd0 : pcm32;
         FMT_NONE:    out_word_in = '0;
         default:     out_word_in = '0;
      endcase
   end

   assign r5        = !out_valid_ff || !rsp_stall;
   assign r4        = !s4_valid_ff || r5;
   assign val_ready = r4;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (r4) s4_valid_ff  <= val_valid;
         if (r5) out_valid_ff <= s4_valid_ff;
      end
      if (r4) begin
         s4_c_ff    <= s4_c_in;
         s4_nan_ff  <= s4_nan_in;
         s4_prod_ff <= s4_prod_in;
         s4_tag_ff  <= val_tag;
      end
      if (r5) begin
         out_word_ff <= out_word_in;
         out_tag_ff  <= s4_tag_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_sample_word   = out_word_ff;
   assign rsp_channel_index = out_tag_ff.channel;
   assign rsp_frame_done    = out_tag_ff.frame_done;
   assign rsp_buffer_done   = out_tag_ff.buffer_done;

endmodule

// ===== rtl/float_audio_to_device_format_unit.sv =====
`timescale 1ns / 1ps
// top level: float audio frame to device sample words
// the first word of a frame passes the frame register, then the adder and encoder stages
// throughput: one word per cycle while rsp_stall is low, so a frame of n channels gives n words,
//   set by the channel sequencer that issues one channel per cycle while the adder takes them
// reset: clears all valid bits; 2 channels, 16-bit pcm, stereo source
module float_audio_to_device_format_unit #(
   parameter int MAX_CHANNELS = fatdf_pkg::DefaultMaxChannels
) (
   input  logic        clock,
   input  logic        reset,
   // frame input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_left_sample,
   input  logic [31:0] req_right_sample,
   input  logic        req_final_frame,
   // word output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_sample_word,
   output logic [2:0]  rsp_channel_index,
   output logic        rsp_frame_done,
   output logic        rsp_buffer_done,
   // register writes
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_data
);
   import fatdf_pkg::*;

   // configuration registers
   logic [3:0] dest_ff, dest_in;
   logic [1:0] format_ff, format_in;
   logic       stereo_ff, stereo_in;

   always_comb begin
      dest_in   = dest_ff;
      format_in = format_ff;
      stereo_in = stereo_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_DEST_CHANNELS: dest_in   = csr_data;
            CSR_SAMPLE_FORMAT: format_in = csr_data[1:0];
            CSR_SOURCE_STEREO: stereo_in = csr_data[0];
            default: ;  // no register there
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_ff   <= 4'd2;
         format_ff <= FMT_PCM16;
         stereo_ff <= 1'b1;
      end else begin
         dest_ff   <= dest_in;
         format_ff <= format_in;
         stereo_ff <= stereo_in;
      end
   end

   // sequencer -> adder
   logic        op_valid, op_ready, op_add;
   logic [31:0] op_a, op_b;
   tag_type     op_tag;

   // adder -> encoder
   logic        val_valid, val_ready;
   logic [31:0] val_word;
   tag_type     val_tag;

   // holds one frame and walks its channels, one word per cycle while the adder takes them
   fatdf_expander #(
      .MAX_CHANNELS(MAX_CHANNELS)
   ) u_expander (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_left_sample (req_left_sample),
      .req_right_sample(req_right_sample),
      .req_final_frame (req_final_frame),
      .dest_channels   (dest_ff),
      .source_stereo   (stereo_ff),
      .op_valid        (op_valid),
      .op_ready        (op_ready),
      .op_a            (op_a),
      .op_b            (op_b),
      .op_add          (op_add),
      .op_tag          (op_tag)
   );

   // three stages: align, add, normalize/round/halve (downmix only)
   fatdf_adder u_adder (
      .clock    (clock),
      .reset    (reset),
      .op_valid (op_valid),
      .op_ready (op_ready),
      .op_a     (op_a),
      .op_b     (op_b),
      .op_add   (op_add),
      .op_tag   (op_tag),
      .val_valid(val_valid),
      .val_ready(val_ready),
      .val_word (val_word),
      .val_tag  (val_tag)
   );

   // two stages: clamp and scale, then round and pack; last register is the output word
   fatdf_encoder u_encoder (
      .clock            (clock),
      .reset            (reset),
      .val_valid        (val_valid),
      .val_ready        (val_ready),
      .val_word         (val_word),
      .val_tag          (val_tag),
      .sample_format    (format_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_word  (rsp_sample_word),
      .rsp_channel_index(rsp_channel_index),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_buffer_done  (rsp_buffer_done)
   );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the float audio to device format unit
module testbench;
   import fatdf_pkg::*;

   // fixed point wide enough to hold any single exactly, lsb = 2^-160
   typedef logic [335:0] wide_type;

   typedef struct {
      logic [31:0] word;
      logic [2:0]  channel;
      logic        frame_done;
      logic        buffer_done;
   } device_word_type;

   typedef struct {
      logic [31:0] left;
      logic [31:0] right;
      logic        final_frame;
      bit          known;
      logic [31:0] word0;
   } frame_row_type;

   localparam int WatchdogLimit = 2000;
   localparam int HoldCycles    = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_left_sample = '0;
   logic [31:0] req_right_sample = '0;
   logic        req_final_frame = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_sample_word;
   logic [2:0]  rsp_channel_index;
   logic        rsp_frame_done;
   logic        rsp_buffer_done;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [3:0]  csr_data = '0;

   // shadow copy of the register file
   logic [3:0]  dest_channels;
   format_type  sample_format;
   logic        source_stereo;

   // predicted channel 0 word of the most recent frame
   logic [31:0] first_word;

   device_word_type pending_words[$];
   frame_row_type   directed_rows[$];
   int  error_count = 0;
   int  frames_sent = 0;
   int  quiet_cycles = 0;
   bit  idling_on = 1'b1;
   bit  hold_request = 1'b0;

   float_audio_to_device_format_unit i_dut (.*);

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- float math

   function automatic bit is_nan(logic [31:0] f);
      return f[30:23] == 8'hFF && f[22:0] != 0;
   endfunction

   function automatic bit is_inf(logic [31:0] f);
      return f[30:23] == 8'hFF && f[22:0] == 0;
   endfunction

   // exact magnitude of a finite single
   function automatic wide_type to_fixed(logic [31:0] f);
      if (f[30:23] == 0) begin
         return wide_type'(f[22:0]) << 11;
      end
      return wide_type'({1'b1, f[22:0]}) << (int'(f[30:23]) + 10);
   endfunction

   // round to nearest even into single precision
   function automatic logic [31:0] round_single(logic sign, wide_type mag);
      int msb;
      int shift;
      wide_type q;
      wide_type rem;
      wide_type half;
      msb = -1;
      if (mag == 0) begin
         return {sign, 31'd0};
      end
      for (int i = 335; i >= 0; i--) begin
         if (mag[i] && msb < 0) msb = i;
      end
      // shift 11 is the subnormal quantum
      shift = (msb - 23 < 11) ? 11 : msb - 23;
      q = mag >> shift;
      rem = mag & ((wide_type'(1) << shift) - 1);
      half = wide_type'(1) << (shift - 1);
      if (rem > half || (rem == half && q[0])) q = q + 1;
      if (q[24]) begin
         q = q >> 1;
         shift++;
      end
      if (!q[23]) begin
         return {sign, 8'd0, q[22:0]};
      end
      if (shift - 10 >= 255) begin
         return {sign, 8'hFF, 23'd0};
      end
      return {sign, 8'(shift - 10), q[22:0]};
   endfunction

   function automatic logic [31:0] add_single(logic [31:0] a, logic [31:0] b);
      wide_type ma;
      wide_type mb;
      if (is_nan(a)) return a | QuietBit;
      if (is_nan(b)) return b | QuietBit;
      if (is_inf(a) && is_inf(b) && a[31] != b[31]) return DefaultNan;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      ma = to_fixed(a);
      mb = to_fixed(b);
      if (a[31] == b[31]) return round_single(a[31], ma + mb);
      if (ma == mb) return 32'd0;
      if (ma > mb) return round_single(a[31], ma - mb);
      return round_single(b[31], mb - ma);
   endfunction

   function automatic logic [31:0] halve_single(logic [31:0] f);
      if (f[30:23] == 8'hFF) return f;
      return round_single(f[31], to_fixed(f) >> 1);
   endfunction

   // v * scale rounded to single, then truncated toward zero
   function automatic logic [31:0] scale_to_pcm(logic [31:0] v, int unsigned scale);
      logic [31:0] product;
      wide_type whole;
      product = round_single(v[31], to_fixed(v) * scale);
      whole = to_fixed(product) >> 160;
      if (whole >= 64'h8000_0000) begin
         return v[31] ? 32'h8000_0000 : Pcm32Max;
      end
      return v[31] ? -whole[31:0] : whole[31:0];
   endfunction

   function automatic logic [31:0] encode_sample(logic [31:0] v);
      // clamp to [-1,1]; nan slips through
      if (!is_nan(v) && v[30:0] > FloatOne[30:0]) v = {v[31], FloatOne[30:0]};
      case (sample_format)
         FMT_FLOAT32: return v;
         FMT_PCM16:   return is_nan(v) ? 32'd0 : {16'd0, scale_to_pcm(v, 32767) & 32'hFFFF};
         FMT_PCM32:   return is_nan(v) ? 32'd0 : scale_to_pcm(v, 32'h7FFF_FFFF);
         default:     return 32'd0;
      endcase
   endfunction

   // expected device words for one accepted frame
   task automatic predict_frame(logic [31:0] left, logic [31:0] right, logic final_frame);
      int count;
      logic [31:0] value;
      device_word_type entry;
      if (!source_stereo) right = left;
      count = (dest_channels == 0) ? 2 : (dest_channels > 8) ? 8 : int'(dest_channels);
      for (int ch = 0; ch < count; ch++) begin
         if (count == 1) value = halve_single(add_single(left, right));
         else if (ch == 0) value = left;
         else if (ch == 1) value = right;
         else value = 32'd0;
         entry.word = encode_sample(value);
         entry.channel = 3'(ch);
         entry.frame_done = (ch == count - 1);
         entry.buffer_done = (ch == count - 1) && final_frame;
         if (ch == 0) first_word = entry.word;
         pending_words.push_back(entry);
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic logic [31:0] pick_sample();
      logic [31:0] specials[16] = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000,
         32'hBF80_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001,
         32'hFFFF_FFFF, 32'h0000_0001, 32'h807F_FFFF, 32'h3F7F_FFFF, 32'h3F80_0001,
         32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h3F00_0000};
      case ($urandom_range(0, 9))
         0, 1: return $urandom;
         2:    return specials[$urandom_range(0, 15)];
         // mostly audio range, some just past full scale
         default: return {1'($urandom), 8'($urandom_range(110, 128)), 23'($urandom)};
      endcase
   endfunction

   task automatic write_register(logic [1:0] index, logic [3:0] value);
      csr_write = 1'b1;
      csr_index = index;
      csr_data = value;
      @(negedge clock);
      csr_write = 1'b0;
      case (index)
         CSR_DEST_CHANNELS: dest_channels = value;
         CSR_SAMPLE_FORMAT: sample_format = format_type'(value[1:0]);
         CSR_SOURCE_STEREO: source_stereo = value[0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [3:0] channels, format_type format, logic stereo);
      write_register(CSR_DEST_CHANNELS, channels);
      write_register(CSR_SAMPLE_FORMAT, 4'(format));
      write_register(CSR_SOURCE_STEREO, 4'(stereo));
   endtask

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_frame(logic [31:0] left, logic [31:0] right, logic final_frame);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_left_sample = left;
      req_right_sample = right;
      req_final_frame = final_frame;
      req_valid = 1'b1;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      predict_frame(left, right, final_frame);
      frames_sent++;
      @(negedge clock);
   endtask

   // let the pipeline empty before touching registers
   task automatic drain();
      req_valid = 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic add_row(logic [31:0] left, logic [31:0] right, logic final_frame,
                          bit known, logic [31:0] word0);
      frame_row_type row;
      row = '{left, right, final_frame, known, word0};
      directed_rows.push_back(row);
   endtask

   // ---------------------------------------------------------------- checking

   // receiver idling, plus one long hold-off to back the unit up
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall = 1'b1;
            repeat (HoldCycles) @(negedge clock);
            rsp_stall = 1'b0;
            hold_request = 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 17)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      device_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            $error("unexpected word: sample_word %h channel %0d", rsp_sample_word,
                   rsp_channel_index);
            error_count++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_sample_word !== want.word) begin
               $error("sample_word: expected %h, actual %h", want.word, rsp_sample_word);
               error_count++;
            end
            if (rsp_channel_index !== want.channel) begin
               $error("channel_index: expected %0d, actual %0d", want.channel,
                      rsp_channel_index);
               error_count++;
            end
            if (rsp_frame_done !== want.frame_done) begin
               $error("frame_done: expected %b, actual %b", want.frame_done,
                      rsp_frame_done);
               error_count++;
            end
            if (rsp_buffer_done !== want.buffer_done) begin
               $error("buffer_done: expected %b, actual %b", want.buffer_done,
                      rsp_buffer_done);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- main flow

   initial begin
      dest_channels = 4'd2;
      sample_format = FMT_PCM16;
      source_stereo = 1'b1;
      repeat (7) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed frames at the reset setting: 2 channels, pcm16, stereo
      add_row(32'h0000_0000, 32'h8000_0000, 1'b0, 1'b1, 32'h0000_0000);
      add_row(32'h3F80_0000, 32'hBF80_0000, 1'b0, 1'b1, 32'h0000_7FFF);
      add_row(32'hBF80_0000, 32'h3F80_0000, 1'b1, 1'b1, 32'h0000_8001);
      add_row(32'h4000_0000, 32'hC000_0000, 1'b0, 1'b1, 32'h0000_7FFF);
      add_row(32'hFF80_0000, 32'h7F80_0000, 1'b0, 1'b1, 32'h0000_8001);
      add_row(32'h7FC0_0000, 32'h7F80_0001, 1'b1, 1'b1, 32'h0000_0000);
      add_row(32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b1, 32'h0000_0000);
      add_row(32'h3F00_0000, 32'h3F7F_FFFF, 1'b0, 1'b0, 32'h0);
      add_row(32'h3F80_0001, 32'h807F_FFFF, 1'b1, 1'b0, 32'h0);
      add_row(32'h7F7F_FFFF, 32'hFF7F_FFFF, 1'b0, 1'b1, 32'h0000_7FFF);
      add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000);
      add_row(32'h3EAA_AAAB, 32'hBE4C_CCCD, 1'b0, 1'b0, 32'h0);
      foreach (directed_rows[i]) begin
         send_frame(directed_rows[i].left, directed_rows[i].right,
                    directed_rows[i].final_frame);
         if (directed_rows[i].known && first_word !== directed_rows[i].word0) begin
            $error("sample_word: expected %h, actual %h", directed_rows[i].word0,
                   first_word);
            error_count++;
         end
      end

      // fixed settings first (extremes, zero and oversize channel counts), then random
      for (int phase = 0; frames_sent < 400; phase++) begin
         drain();
         case (phase)
            0: configure(4'd1, FMT_FLOAT32, 1'b1);
            1: configure(4'd1, FMT_PCM32, 1'b1);
            2: configure(4'd8, FMT_PCM32, 1'b1);
            3: configure(4'd0, FMT_FLOAT32, 1'b0);
            4: configure(4'd15, FMT_NONE, 1'b0);
            5: configure(4'd1, FMT_PCM16, 1'b0);
            6: configure(4'd9, FMT_PCM16, 1'b1);
            default: configure(4'($urandom_range(0, 15)), format_type'($urandom_range(0, 3)),
                               1'($urandom));
         endcase
         // fill the unit up with the output held off
         if (phase == 2) hold_request = 1'b1;
         if (frames_sent >= 360) idling_on = 1'b0;
         repeat (25) begin
            send_frame(pick_sample(), pick_sample(), $urandom_range(0, 3) == 0);
         end
      end

      drain();
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
